@@ rtl/ptf_pkg.sv @@
package ptf_pkg;

    localparam int ANG_W = 8;

    localparam logic [7:0] ANG_MIN  = 8'd45;
    localparam logic [7:0] ANG_MAX  = 8'd135;
    localparam logic [7:0] ANG_HOME = 8'd90;
    localparam logic [7:0] TILT_CENTER = 8'd120;
    localparam logic [7:0] PAN_CENTER  = 8'd160;
    localparam logic [6:0] FWD_MAX = 7'd60;
    localparam logic signed [7:0] SCAN_TURN_POS = 8'sd80;
    localparam logic signed [7:0] SCAN_TURN_NEG = -8'sd80;

    localparam logic [12:0] RST_RANGE_SETPOINT = 13'd700;
    localparam logic [12:0] RST_RANGE_LIMIT    = 13'd2500;
    localparam logic [5:0]  RST_TURN_DEADBAND  = 6'd10;
    localparam logic [15:0] RST_SCAN_OPEN      = 16'd1500;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RANGE_SETPOINT = 2'd0,
        CFG_RANGE_LIMIT    = 2'd1,
        CFG_TURN_DEADBAND  = 2'd2,
        CFG_SCAN_OPEN      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [12:0] range_setpoint_mm;
        logic [12:0] range_limit_mm;
        logic [5:0]  turn_deadband_deg;
        logic [15:0] scan_open_tenths_cm;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic        target_found;
        logic [8:0]  target_x;
        logic [7:0]  target_y;
        logic        range_valid;
        logic [15:0] range_mm;
        logic [15:0] left_tenths_cm;
        logic [15:0] right_tenths_cm;
    } item_t;

    typedef struct packed {
        logic              drive_valid;
        logic signed [6:0] forward_speed;
        logic signed [7:0] turn_speed;
        logic [7:0]        pan_angle;
        logic [7:0]        tilt_angle;
        logic              scanning;
    } result_t;

    typedef struct packed {
        logic [ANG_W-1:0] pan;
        logic [ANG_W-1:0] tilt;
        logic             scanning;
    } state_t;

    // n / 20 for n below 1024*4: drop two bits, then divide by 5 with 205/1024
    function automatic logic [7:0] div20(input logic [11:0] n);
        logic [19:0] p;
        p = {10'd0, n[11:2]} * 20'd205;
        return p[17:10];
    endfunction

    // nudge an angle toward the image center, clamp to the servo range
    function automatic logic [7:0] nudge_angle(input logic [7:0] cur,
                                               input logic [8:0] pos,
                                               input logic [7:0] center);
        logic [11:0] num;
        logic [7:0]  q;
        num = {4'd0, cur} * 12'd20 + {4'd0, center} - {3'd0, pos};
        q   = div20(num);
        if (q < ANG_MIN)
            return ANG_MIN;
        else if (q > ANG_MAX)
            return ANG_MAX;
        else
            return q;
    endfunction

endpackage

@@ rtl/ptf_cfg.sv @@
module ptf_cfg
    import ptf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_setpoint_mm   <= RST_RANGE_SETPOINT;
            cfg_reg.range_limit_mm      <= RST_RANGE_LIMIT;
            cfg_reg.turn_deadband_deg   <= RST_TURN_DEADBAND;
            cfg_reg.scan_open_tenths_cm <= RST_SCAN_OPEN;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_RANGE_SETPOINT: cfg_reg.range_setpoint_mm   <= cfg_wdata[12:0];
                CFG_RANGE_LIMIT:    cfg_reg.range_limit_mm      <= cfg_wdata[12:0];
                CFG_TURN_DEADBAND:  cfg_reg.turn_deadband_deg   <= cfg_wdata[5:0];
                CFG_SCAN_OPEN:      cfg_reg.scan_open_tenths_cm <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ptf_step.sv @@
module ptf_step
    import ptf_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output result_t result,
    output state_t  state_next
);

    state_t            st0;
    logic [7:0]        pan_trk;
    logic [7:0]        tilt_trk;
    logic signed [8:0] off;
    logic              off_neg;
    logic [5:0]        off_mag;
    logic signed [9:0] t3;
    logic signed [9:0] t3r;
    logic signed [7:0] turn_trk;
    logic signed [16:0] diff;
    logic signed [18:0] diff3;
    logic              diff_neg;
    logic [17:0]       fmag;
    logic [26:0]       fprod;
    logic [10:0]       fq;
    logic [6:0]        fq_sat;
    logic signed [6:0] fwd_trk;
    logic              fwd_en;
    logic              left_open;

    always_comb
    begin
        // start command homes the head and forces tracking
        if (item.op)
        begin
            st0.pan      = ANG_HOME;
            st0.tilt     = ANG_HOME;
            st0.scanning = 1'b0;
        end
        else
        begin
            st0 = state;
        end

        tilt_trk = nudge_angle(st0.tilt, {1'b0, item.target_y}, TILT_CENTER);
        pan_trk  = nudge_angle(st0.pan, item.target_x, PAN_CENTER);

        // body turn: 1.5 * pan offset, truncated toward zero
        off     = $signed({1'b0, pan_trk}) - $signed({1'b0, ANG_HOME});
        off_neg = off[8];
        off_mag = off_neg ? 6'(-off) : 6'(off);
        t3      = {off[8], off} + {off, 1'b0};
        t3r     = off_neg ? t3 + 10'sd1 : t3;
        if (off_mag > cfg.turn_deadband_deg)
            turn_trk = t3r[8:1];
        else
            turn_trk = 8'sd0;

        // forward: 0.15 * range error, truncated toward zero, clamped
        diff     = $signed({1'b0, item.range_mm}) - $signed({4'd0, cfg.range_setpoint_mm});
        diff3    = {{2{diff[16]}}, diff} + {diff[16], diff, 1'b0};
        diff_neg = diff3[18];
        fmag     = diff_neg ? 18'(-diff3) : 18'(diff3);
        fprod    = {14'd0, fmag[14:2]} * 27'd13108;
        fq       = fprod[26:16];
        fq_sat   = (fq > {4'd0, FWD_MAX}) ? FWD_MAX : fq[6:0];
        fwd_trk  = diff_neg ? -$signed(fq_sat) : $signed(fq_sat);
        fwd_en   = item.range_valid && (item.range_mm < {3'd0, cfg.range_limit_mm});

        left_open = (item.left_tenths_cm > cfg.scan_open_tenths_cm)
                 && (item.left_tenths_cm > item.right_tenths_cm);

        state_next           = st0;
        result.drive_valid   = 1'b0;
        result.forward_speed = 7'sd0;
        result.turn_speed    = 8'sd0;

        if (!st0.scanning)
        begin
            if (item.target_found)
            begin
                state_next.pan       = pan_trk;
                state_next.tilt      = tilt_trk;
                result.drive_valid   = 1'b1;
                result.turn_speed    = turn_trk;
                result.forward_speed = fwd_en ? fwd_trk : 7'sd0;
            end
            else
            begin
                // lost the target: start scanning, no drive command
                state_next.scanning = 1'b1;
            end
        end
        else
        begin
            result.drive_valid  = 1'b1;
            result.turn_speed   = left_open ? SCAN_TURN_NEG : SCAN_TURN_POS;
            state_next.scanning = !item.target_found;
        end

        result.pan_angle  = state_next.pan;
        result.tilt_angle = state_next.tilt;
        result.scanning   = state_next.scanning;
    end

endmodule

@@ rtl/pan_tilt_follow_controller.sv @@
// An input beat goes through the input register, then the result register, to a result beat.
// Throughput: one beat per cycle when not stalled; the state update is a single pass
// of the step logic, so the next beat sees the new pan, tilt and mode right away.
// Reset (rst_n low, asynchronous): pan and tilt 90, tracking mode, registers at their
// defaults, both pipeline registers empty.
module pan_tilt_follow_controller
    import ptf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // target_found, target_x[8:0], target_y[7:0], range_valid, range_mm[15:0],
    // left_tenths_cm[15:0], right_tenths_cm[15:0], zero fill
    input  logic [71:0]           s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // drive_valid, forward_speed[6:0], turn_speed[7:0], pan_angle[7:0],
    // tilt_angle[7:0], scanning, zero fill
    output logic [39:0]           m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    advance;
    logic    fire;

    ptf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptf_step u_step (
        .item       (in_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .result     (res_next),
        .state_next (state_next)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.op              <= s_axis_tuser;
            in_reg.target_found    <= s_axis_tdata[0];
            in_reg.target_x        <= s_axis_tdata[9:1];
            in_reg.target_y        <= s_axis_tdata[17:10];
            in_reg.range_valid     <= s_axis_tdata[18];
            in_reg.range_mm        <= s_axis_tdata[34:19];
            in_reg.left_tenths_cm  <= s_axis_tdata[50:35];
            in_reg.right_tenths_cm <= s_axis_tdata[66:51];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pan      <= ANG_HOME;
            state_reg.tilt     <= ANG_HOME;
            state_reg.scanning <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (fire)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            res_reg.scanning,
                            res_reg.tilt_angle,
                            res_reg.pan_angle,
                            res_reg.turn_speed,
                            res_reg.forward_speed,
                            res_reg.drive_valid};

endmodule
